@@ sv/galf_pkg.sv @@
package galf_pkg;

  localparam int READING_BITS = 12;

  localparam int PHASE_W = 2;
  localparam int RAW_W   = 12;
  localparam int PPM_W   = 16;
  localparam int STATE_W = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RAW_USE_BITS = (READING_BITS < RAW_W) ? READING_BITS : RAW_W;
  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << RAW_USE_BITS) - 64'd1);

  typedef enum logic [STATE_W-1:0] {
    ST_WARMUP  = 3'd0,
    ST_NORMAL  = 3'd1,
    ST_WARNING = 3'd2,
    ST_ALARM   = 3'd3,
    ST_ERROR   = 3'd4
  } alarm_state_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_HIGH    = 2'd0,
    PH_LOW     = 2'd1,
    PH_MEASURE = 2'd2,
    PH_OTHER   = 2'd3
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    LED_OFF       = 2'd0,
    LED_SLOW      = 2'd1,
    LED_FAST      = 2'd2,
    LED_HEARTBEAT = 2'd3
  } led_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_LIMIT    = 2'd0,
    CFG_WARNING_LIMIT   = 2'd1,
    CFG_EMERGENCY_LIMIT = 2'd2,
    CFG_FAULT_FLOOR     = 2'd3
  } cfg_index_t;

endpackage

@@ sv/gas_alarm_level_fsm.sv @@
// gas alarm level state machine: one transaction in per sensor service tick, one
// transaction out for each. every input transaction gives a result carrying the
// new alarm state (warmup, normal, warning, alarm, error), the green and red led
// modes, the siren flag, a one-time warmup beep pulse and a state-change flag.
// the block takes a new transaction every clock cycle while the output is not
// stalled; a transaction is held in the input register and then sits in the
// result register, which holds it for as long as the output is stalled. the
// alarm state advances as a transaction moves from the input register to the
// result register. the four limit registers are written through the cfg port,
// which is always ready; write them only while no transaction is in flight.
module gas_alarm_level_fsm
  import galf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PHASE_W-1:0]    in_heater_phase,
  input  logic                  in_sensor_fault,
  input  logic [RAW_W-1:0]      in_raw_reading,
  input  logic [PPM_W-1:0]      in_gas_ppm,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATE_W-1:0]    out_alarm_state,
  output logic [MODE_W-1:0]     out_green_led,
  output logic [MODE_W-1:0]     out_red_led,
  output logic                  out_siren_on,
  output logic                  out_beep_pulse,
  output logic                  out_mode_changed,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PPM_W-1:0] normal_limit_r;
  logic [PPM_W-1:0] warning_limit_r;
  logic [RAW_W-1:0] emergency_limit_r;
  logic [RAW_W-1:0] fault_floor_r;

  alarm_state_t state_r, state_nxt;
  logic         beep_given_r, beep_given_nxt;
  logic         beep_nxt;

  logic             s1_valid_r;
  phase_t           s1_phase_r;
  logic             s1_fault_r;
  logic [RAW_W-1:0] s1_raw_r;
  logic [PPM_W-1:0] s1_ppm_r;

  logic              out_valid_r;
  logic [STATE_W-1:0] out_state_r;
  led_mode_t         out_green_r, out_red_r;
  logic              out_siren_r, out_beep_r, out_changed_r;

  led_mode_t green_nxt, red_nxt;
  logic      siren_nxt;

  logic out_load;
  logic in_take;
  logic [RAW_W-1:0] raw_used;

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign raw_used = s1_raw_r & RAW_MASK;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_limit_r    <= PPM_W'(50);
      warning_limit_r   <= PPM_W'(150);
      emergency_limit_r <= RAW_W'(3000);
      fault_floor_r     <= RAW_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NORMAL_LIMIT:    normal_limit_r    <= cfg_data;
        CFG_WARNING_LIMIT:   warning_limit_r   <= cfg_data;
        CFG_EMERGENCY_LIMIT: emergency_limit_r <= cfg_data[RAW_W-1:0];
        CFG_FAULT_FLOOR:     fault_floor_r     <= cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_phase_r <= phase_t'(in_heater_phase);
      s1_fault_r <= in_sensor_fault;
      s1_raw_r   <= in_raw_reading;
      s1_ppm_r   <= in_gas_ppm;
    end
  end

  // next state
  always_comb begin
    state_nxt      = state_r;
    beep_given_nxt = beep_given_r;
    beep_nxt       = 1'b0;
    if (s1_fault_r || (raw_used < fault_floor_r)) begin
      state_nxt = ST_ERROR;
    end else begin
      unique case (state_r)
        ST_ERROR: state_nxt = ST_NORMAL;
        ST_WARMUP: begin
          if (s1_phase_r == PH_HIGH && !beep_given_r) begin
            beep_nxt       = 1'b1;
            beep_given_nxt = 1'b1;
          end
          if (s1_phase_r == PH_MEASURE) state_nxt = ST_NORMAL;
        end
        ST_NORMAL, ST_WARNING, ST_ALARM: begin
          if (s1_phase_r == PH_LOW) begin
            if (raw_used > emergency_limit_r) state_nxt = ST_ALARM;
          end else if (s1_phase_r == PH_MEASURE) begin
            priority if (state_r == ST_NORMAL) begin
              if (s1_ppm_r > warning_limit_r)     state_nxt = ST_ALARM;
              else if (s1_ppm_r > normal_limit_r) state_nxt = ST_WARNING;
            end else if (state_r == ST_WARNING) begin
              if (s1_ppm_r > warning_limit_r)     state_nxt = ST_ALARM;
              else if (s1_ppm_r < normal_limit_r) state_nxt = ST_NORMAL;
            end else begin
              if (s1_ppm_r < normal_limit_r)       state_nxt = ST_NORMAL;
              else if (s1_ppm_r < warning_limit_r) state_nxt = ST_WARNING;
            end
          end
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  // led and siren decode
  always_comb begin
    green_nxt = LED_OFF;
    red_nxt   = LED_OFF;
    siren_nxt = 1'b0;
    unique case (state_nxt)
      ST_WARMUP:  green_nxt = LED_SLOW;
      ST_NORMAL:  green_nxt = LED_HEARTBEAT;
      ST_WARNING: red_nxt   = LED_FAST;
      ST_ALARM: begin
        red_nxt   = LED_FAST;
        siren_nxt = 1'b1;
      end
      ST_ERROR:   red_nxt   = LED_SLOW;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WARMUP;
      beep_given_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        state_r      <= state_nxt;
        beep_given_r <= beep_given_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_state_r   <= state_nxt;
      out_green_r   <= green_nxt;
      out_red_r     <= red_nxt;
      out_siren_r   <= siren_nxt;
      out_beep_r    <= beep_nxt;
      out_changed_r <= (state_nxt != state_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_alarm_state  = out_state_r;
  assign out_green_led    = out_green_r;
  assign out_red_led      = out_red_r;
  assign out_siren_on     = out_siren_r;
  assign out_beep_pulse   = out_beep_r;
  assign out_mode_changed = out_changed_r;

endmodule

@@ sv/galf_chk.sv @@
module galf_chk
  import galf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATE_W-1:0]    out_alarm_state,
  input logic [MODE_W-1:0]     out_green_led,
  input logic [MODE_W-1:0]     out_red_led,
  input logic                  out_siren_on,
  input logic                  out_beep_pulse,
  input logic                  out_mode_changed
);

  a_siren_only_in_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_siren_on |-> out_alarm_state == ST_ALARM && out_red_led == LED_FAST)
    else $error("siren on outside alarm");

  a_beep_only_in_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep_pulse |-> out_alarm_state == ST_WARMUP && !out_mode_changed)
    else $error("beep outside warmup");

  a_normal_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_state == ST_NORMAL
      |-> out_green_led == LED_HEARTBEAT && out_red_led == LED_OFF)
    else $error("normal state led modes wrong");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alarm_state)
      && $stable(out_mode_changed) && $stable(out_beep_pulse))
    else $error("stalled result changed");

endmodule

bind gas_alarm_level_fsm galf_chk u_galf_chk (.*);
